// ===== rtl/mwm_pkg.sv =====
// mwm_pkg: shared types, constants and helpers of the 3d maze wall map
// depends on nothing; used by maze_wall_map_3d, mwm_front, mwm_queue and mwm_back
`default_nettype none
package mwm_pkg;

	// configured maze size limits
	localparam int SIZE_W = 4;
	localparam logic [SIZE_W-1:0] MAX_ROWS    = 4'd15;
	localparam logic [SIZE_W-1:0] MAX_COLUMNS = 4'd15;
	localparam logic [SIZE_W-1:0] MAX_FLOORS  = 4'd15;
	localparam logic [SIZE_W-1:0] SIZE_RESET  = 4'd15;

	// raw coordinate and storage address widths
	localparam int IDX_W  = 5;
	localparam int ADDR_W = 3 * IDX_W;
	localparam int CNT_W  = 32;
	localparam int MASK_W = 6;

	// apb register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_ROWS    = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_FLOORS  = 2'd2;

	// operation codes of an input item
	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_TOGGLE = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_INIT   = 3'd4;

	// work kinds handed from front to back
	typedef enum logic [2:0] {
		CMD_READ,
		CMD_WRITE,
		CMD_TOGGLE,
		CMD_QUERY,
		CMD_INIT,
		CMD_PASS
	} cmd_kind_t;

	// one classified item; coordinates are raw (query: raw centre cell)
	typedef struct packed {
		cmd_kind_t        kind;
		logic             err;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] flr;
		logic             wv;
		logic [IDX_W-1:0] row_last;
		logic [IDX_W-1:0] col_last;
		logic [IDX_W-1:0] flr_last;
	} mwm_cmd_t;

	// zero acts as one, anything above the limit acts as the limit
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = {{(SIZE_W-1){1'b0}}, 1'b1};
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// storage address of a raw cell
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] flr);
		return {flr, row, col};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mwm_req_if.sv =====
// mwm_req_if: input item channel of the 3d maze wall map
// depends on nothing
`default_nettype none
interface mwm_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [4:0] row_index;
	logic [4:0] column_index;
	logic [4:0] floor_index;
	logic       write_value;

	modport source (output valid, output operation, output row_index, output column_index,
		output floor_index, output write_value, input ready);
	modport sink (input valid, input operation, input row_index, input column_index,
		input floor_index, input write_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/mwm_rsp_if.sv =====
// mwm_rsp_if: result item channel of the 3d maze wall map
// depends on nothing
`default_nettype none
interface mwm_rsp_if;
	logic        valid;
	logic        ready;
	logic        cell_value;
	logic [5:0]  open_mask;
	logic        error_code;
	logic [31:0] change_count;

	modport source (output valid, output cell_value, output open_mask, output error_code,
		output change_count, input ready);
	modport sink (input valid, input cell_value, input open_mask, input error_code,
		input change_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/maze_wall_map_3d.sv =====
// maze_wall_map_3d: top level of the 3d maze wall map
// depends on mwm_pkg, mwm_req_if, mwm_rsp_if, mwm_front, mwm_queue and mwm_back
//
// usage: items arrive on req (valid/ready) and each gives exactly one item on rsp.
// operations: read, write, toggle of one raw wall bit, directions query of a maze
// cell (six-bit open-side mask), and initialize of the configured raw volume.
// the maze size sits in three apb registers (rows at 0x0, columns at 0x4, floors
// at 0x8); write them only while no item is in flight.
// the front classifies and range-checks items into a two-entry queue; the back
// runs them against a single-port wall bit memory, one access per cycle.
// in the back, read, write and toggle pass through the issue and wait states,
// rejected items and unused codes through the issue state only, a directions
// query makes six neighbour reads through the one port, and initialize sweeps
// all (2R+1)(2C+1)(2F+1) raw cells, one bit written a cycle.
// an accepted item may also wait behind earlier items before its result is valid.
// a finished result waits in the output register while the queue still takes
// items; when rsp stalls the back takes no next item and the queue fills.
// reset: size registers go to 15, the counter to zero; the wall bits hold no
// defined value until the first initialize.
`default_nettype none
module maze_wall_map_3d import mwm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mwm_req_if.sink                 req,
	mwm_rsp_if.source               rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	logic     q_full, q_push, q_empty, q_pop;
	mwm_cmd_t q_cmd, q_head;

	// intake and configuration
	mwm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	// decoupling queue
	mwm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	// execution and results
	mwm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

// ===== rtl/mwm_front.sv =====
// mwm_front: size registers on the apb port, item intake and classification
// depends on mwm_pkg and mwm_req_if
`default_nettype none
module mwm_front import mwm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// item intake
	mwm_req_if.sink                 req,
	// queue push side
	input  wire logic               q_full,
	output logic                    q_push,
	output mwm_cmd_t                q_cmd
);

	logic [SIZE_W-1:0] rows_q, cols_q, flrs_q;
	logic [SIZE_W-1:0] rows, cols, flrs;
	logic [1:0]        reg_idx;
	logic              cfg_wr;
	logic [IDX_W-1:0]  rlast, clast, flast;
	logic              raw_bad, maze_bad;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SIZE_RESET;
			cols_q <= SIZE_RESET;
			flrs_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROWS:    rows_q <= pwdata[SIZE_W-1:0];
				REG_COLUMNS: cols_q <= pwdata[SIZE_W-1:0];
				REG_FLOORS:  flrs_q <= pwdata[SIZE_W-1:0];
				default:     ;
			endcase
		end
	end

	// register read back
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ROWS:    prdata[SIZE_W-1:0] = rows_q;
			REG_COLUMNS: prdata[SIZE_W-1:0] = cols_q;
			REG_FLOORS:  prdata[SIZE_W-1:0] = flrs_q;
			default:     prdata = '0;
		endcase
	end

	// effective sizes and last raw index on each axis
	assign rows  = clamp_size(rows_q, MAX_ROWS);
	assign cols  = clamp_size(cols_q, MAX_COLUMNS);
	assign flrs  = clamp_size(flrs_q, MAX_FLOORS);
	assign rlast = {rows, 1'b0};
	assign clast = {cols, 1'b0};
	assign flast = {flrs, 1'b0};

	assign raw_bad  = (req.row_index > rlast) || (req.column_index > clast) ||
		(req.floor_index > flast);
	assign maze_bad = (req.row_index >= {1'b0, rows}) || (req.column_index >= {1'b0, cols}) ||
		(req.floor_index >= {1'b0, flrs});

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	// classify the item
	always_comb begin
		q_cmd          = '0;
		q_cmd.kind     = CMD_PASS;
		q_cmd.row      = req.row_index;
		q_cmd.col      = req.column_index;
		q_cmd.flr      = req.floor_index;
		q_cmd.wv       = req.write_value;
		q_cmd.row_last = rlast;
		q_cmd.col_last = clast;
		q_cmd.flr_last = flast;
		unique case (req.operation) inside
			OP_READ, OP_WRITE, OP_TOGGLE: begin
				if (raw_bad) begin
					q_cmd.err = 1'b1;
				end else if (req.operation == OP_READ) begin
					q_cmd.kind = CMD_READ;
				end else if (req.operation == OP_WRITE) begin
					q_cmd.kind = CMD_WRITE;
				end else begin
					q_cmd.kind = CMD_TOGGLE;
				end
			end
			OP_QUERY: begin
				if (maze_bad) begin
					q_cmd.err = 1'b1;
				end else begin
					// maze cell n sits at raw 2n+1
					q_cmd.kind = CMD_QUERY;
					q_cmd.row  = {req.row_index[IDX_W-2:0], 1'b1};
					q_cmd.col  = {req.column_index[IDX_W-2:0], 1'b1};
					q_cmd.flr  = {req.floor_index[IDX_W-2:0], 1'b1};
				end
			end
			OP_INIT: q_cmd.kind = CMD_INIT;
			default: q_cmd.kind = CMD_PASS;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/mwm_queue.sv =====
// mwm_queue: two-entry command queue between front and back
// depends on mwm_pkg
`default_nettype none
module mwm_queue import mwm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire mwm_cmd_t push_cmd,
	output logic          full,
	input  wire logic     pop,
	output logic          empty,
	output mwm_cmd_t      head
);

	mwm_cmd_t   slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign head  = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

// ===== rtl/mwm_back.sv =====
// mwm_back: wall bit memory, command sequencer, counter and result register
// depends on mwm_pkg and mwm_rsp_if
`default_nettype none
module mwm_back import mwm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	// queue pop side
	input  wire logic     q_empty,
	input  wire mwm_cmd_t q_head,
	output logic          q_pop,
	// result channel
	mwm_rsp_if.source     rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_QUERY,
		ST_SWEEP
	} state_t;

	localparam int DEPTH = 1 << ADDR_W;

	state_t            state_q;
	mwm_cmd_t          cmd_q;
	logic [CNT_W-1:0]  count_q;
	logic [2:0]        qstep_q;
	logic [MASK_W-1:0] mask_q, mask_nxt;
	logic [IDX_W-1:0]  sw_row_q, sw_col_q, sw_flr_q;
	logic              out_valid_q, out_cell_q, out_err_q;
	logic [MASK_W-1:0] out_mask_q;

	logic              mem_q [DEPTH];
	logic              rdata_q;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we, mem_wd;
	logic              face, pillar;
	logic [IDX_W-1:0]  nb_row, nb_col, nb_flr;

	assign q_pop = (state_q == ST_IDLE) && !q_empty && (!out_valid_q || rsp.ready);

	// neighbour of the query cell for the current step
	always_comb begin
		nb_row = cmd_q.row;
		nb_col = cmd_q.col;
		nb_flr = cmd_q.flr;
		case (qstep_q)
			3'd0:    nb_row = cmd_q.row - IDX_W'(1);
			3'd1:    nb_flr = cmd_q.flr + IDX_W'(1);
			3'd2:    nb_row = cmd_q.row + IDX_W'(1);
			3'd3:    nb_flr = cmd_q.flr - IDX_W'(1);
			3'd4:    nb_col = cmd_q.col + IDX_W'(1);
			3'd5:    nb_col = cmd_q.col - IDX_W'(1);
			default: ;
		endcase
	end

	// open-side mask with the bit that arrives this cycle merged in
	always_comb begin
		mask_nxt = mask_q;
		if (qstep_q != 3'd0) mask_nxt[qstep_q - 3'd1] = ~rdata_q;
	end

	// initial pattern: outer faces and all-even pillars are wall
	assign face = (sw_row_q == '0) || (sw_row_q == cmd_q.row_last) ||
		(sw_col_q == '0) || (sw_col_q == cmd_q.col_last) ||
		(sw_flr_q == '0) || (sw_flr_q == cmd_q.flr_last);
	assign pillar = !(sw_row_q[0] | sw_col_q[0] | sw_flr_q[0]);

	// memory port control
	always_comb begin
		mem_addr = cell_addr(cmd_q.row, cmd_q.col, cmd_q.flr);
		mem_we   = 1'b0;
		mem_wd   = 1'b0;
		unique case (state_q)
			ST_WAIT: begin
				if (cmd_q.kind == CMD_WRITE) begin
					mem_we = (rdata_q != cmd_q.wv);
					mem_wd = cmd_q.wv;
				end else if (cmd_q.kind == CMD_TOGGLE) begin
					mem_we = 1'b1;
					mem_wd = ~rdata_q;
				end
			end
			ST_QUERY: mem_addr = cell_addr(nb_row, nb_col, nb_flr);
			ST_SWEEP: begin
				mem_addr = cell_addr(sw_row_q, sw_col_q, sw_flr_q);
				mem_we   = 1'b1;
				mem_wd   = face | pillar;
			end
			default: ;
		endcase
	end

	// single-port wall bit memory, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_addr] <= mem_wd;
		rdata_q <= mem_q[mem_addr];
	end

	// sequencer, counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			qstep_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// the result register only holds an item while idle
					if (rsp.ready) out_valid_q <= 1'b0;
					if (q_pop) begin
						cmd_q    <= q_head;
						qstep_q  <= '0;
						mask_q   <= '0;
						sw_row_q <= '0;
						sw_col_q <= '0;
						sw_flr_q <= '0;
						if (q_head.kind == CMD_QUERY) begin
							state_q <= ST_QUERY;
						end else if (q_head.kind == CMD_INIT) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					if (cmd_q.kind == CMD_PASS) begin
						out_valid_q <= 1'b1;
						out_cell_q  <= 1'b0;
						out_mask_q  <= '0;
						out_err_q   <= cmd_q.err;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					out_valid_q <= 1'b1;
					out_mask_q  <= '0;
					out_err_q   <= 1'b0;
					state_q     <= ST_IDLE;
					case (cmd_q.kind)
						CMD_WRITE: begin
							out_cell_q <= cmd_q.wv;
							if (rdata_q != cmd_q.wv) count_q <= count_q + CNT_W'(1);
						end
						CMD_TOGGLE: begin
							out_cell_q <= ~rdata_q;
							count_q    <= count_q + CNT_W'(1);
						end
						default: out_cell_q <= rdata_q;
					endcase
				end
				ST_QUERY: begin
					mask_q  <= mask_nxt;
					qstep_q <= qstep_q + 3'd1;
					if (qstep_q == 3'd6) begin
						out_valid_q <= 1'b1;
						out_cell_q  <= 1'b0;
						out_mask_q  <= mask_nxt;
						out_err_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					// column fastest, then row, then floor
					if (sw_col_q != cmd_q.col_last) begin
						sw_col_q <= sw_col_q + IDX_W'(1);
					end else begin
						sw_col_q <= '0;
						if (sw_row_q != cmd_q.row_last) begin
							sw_row_q <= sw_row_q + IDX_W'(1);
						end else begin
							sw_row_q <= '0;
							if (sw_flr_q != cmd_q.flr_last) begin
								sw_flr_q <= sw_flr_q + IDX_W'(1);
							end else begin
								count_q     <= '0;
								out_valid_q <= 1'b1;
								out_cell_q  <= 1'b0;
								out_mask_q  <= '0;
								out_err_q   <= 1'b0;
								state_q     <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.cell_value   = out_cell_q;
	assign rsp.open_mask    = out_mask_q;
	assign rsp.error_code   = out_err_q;
	assign rsp.change_count = count_q;

endmodule
`default_nettype wire
